FILE: src/mpf_pkg.sv
package mpf_pkg;

    localparam int ELEM_W     = 32;
    localparam int PEAK_ROW_W = 5;
    localparam int PEAK_COL_W = 5;
    localparam int PEAK_VAL_W = 32;
    localparam int CFG_DIM_W  = 6;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [CFG_DIM_W-1:0] NUM_ROWS_RST = 6'd32;
    localparam logic [CFG_DIM_W-1:0] NUM_COLS_RST = 6'd32;

    // register index, taken from paddr[2]
    localparam logic REG_NUM_ROWS = 1'b0;
    localparam logic REG_NUM_COLS = 1'b1;

    typedef struct packed {
        logic [PEAK_ROW_W-1:0] row;
        logic [PEAK_COL_W-1:0] col;
        logic [PEAK_VAL_W-1:0] value;
    } t_peak;

    typedef struct packed {
        logic idle;
        logic done;
    } t_srch_stat;

endpackage

FILE: src/mpf_in_if.sv
interface mpf_in_if;
    logic                        valid;
    logic                        ready;
    logic [mpf_pkg::ELEM_W-1:0]  element_value;

    modport source (output valid, output element_value, input ready);
    modport sink   (input valid, input element_value, output ready);
endinterface

FILE: src/mpf_out_if.sv
interface mpf_out_if;
    logic                            valid;
    logic                            ready;
    logic [mpf_pkg::PEAK_ROW_W-1:0]  peak_row;
    logic [mpf_pkg::PEAK_COL_W-1:0]  peak_col;
    logic [mpf_pkg::PEAK_VAL_W-1:0]  peak_value;

    modport source (output valid, output peak_row, output peak_col, output peak_value,
                    input ready);
    modport sink   (input valid, input peak_row, input peak_col, input peak_value,
                    output ready);
endinterface

FILE: src/mpf_search.sv
module mpf_search #(
    parameter int MAX_ROWS   = 32,
    parameter int MAX_COLS   = 32,
    parameter int VALUE_BITS = 32,
    parameter int ROWS_CW    = 6,
    parameter int COLS_CW    = 6,
    parameter int ADDR_W     = 10
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_wr_en,
    input  logic [ADDR_W-1:0]         i_wr_addr,
    input  logic [VALUE_BITS-1:0]     i_wr_data,
    input  logic                      i_start,
    input  logic [ROWS_CW-1:0]        i_rows,
    input  logic [COLS_CW-1:0]        i_cols,
    input  logic                      i_take,
    output mpf_pkg::t_srch_stat       o_stat,
    output mpf_pkg::t_peak            o_peak
);
    import mpf_pkg::*;

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_START    = 9'b000000010,
        S_SCAN     = 9'b000000100,
        S_SCAN_END = 9'b000001000,
        S_CHK_L    = 9'b000010000,
        S_WAIT_L   = 9'b000100000,
        S_CHK_R    = 9'b001000000,
        S_WAIT_R   = 9'b010000000,
        S_DONE     = 9'b100000000
    } t_state;

    logic [VALUE_BITS-1:0] r_mem [DEPTH];
    logic [VALUE_BITS-1:0] r_rdata;

    t_state                r_state, n_state;
    logic [ROWS_CW-1:0]    r_rows;
    logic [COLS_CW-1:0]    r_cols;
    logic [COL_W-1:0]      r_left, n_left;
    logic [COL_W-1:0]      r_right, n_right;
    logic [COL_W-1:0]      r_mid, n_mid;
    logic [ROW_W-1:0]      r_row, n_row;
    logic [ADDR_W-1:0]     r_addr, n_addr;
    logic                  r_dv;
    logic [ROW_W-1:0]      r_dv_row;
    logic [ADDR_W-1:0]     r_dv_addr;
    logic [VALUE_BITS-1:0] r_best;
    logic [ROW_W-1:0]      r_best_row;
    logic [ADDR_W-1:0]     r_best_addr;

    logic                  w_rd_en;
    logic [ADDR_W-1:0]     w_rd_addr;
    logic                  w_scan_issue;
    logic                  w_gt;
    logic                  w_eq;
    logic                  w_ge;
    logic [COL_W:0]        w_span_sum;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rdata <= r_mem[w_rd_addr];
        end
    end

    // shared compare unit
    assign w_gt = r_rdata > r_best;
    assign w_eq = r_rdata == r_best;
    assign w_ge = w_gt | w_eq;

    assign w_span_sum = {1'b0, r_left} + {1'b0, r_right};

    always_comb begin
        n_state      = r_state;
        n_left       = r_left;
        n_right      = r_right;
        n_mid        = r_mid;
        n_row        = r_row;
        n_addr       = r_addr;
        w_rd_en      = 1'b0;
        w_rd_addr    = r_addr;
        w_scan_issue = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_left  = '0;
                    n_right = COL_W'(i_cols - COLS_CW'(1));
                    n_state = S_START;
                end
            end
            S_START: begin
                n_mid   = w_span_sum[COL_W:1];
                n_addr  = ADDR_W'(w_span_sum[COL_W:1]);
                n_row   = '0;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                w_rd_en      = 1'b1;
                w_rd_addr    = r_addr;
                w_scan_issue = 1'b1;
                n_addr       = r_addr + ADDR_W'(r_cols);
                n_row        = r_row + ROW_W'(1);
                if (r_row == ROW_W'(r_rows - ROWS_CW'(1))) begin
                    n_state = S_SCAN_END;
                end
            end
            S_SCAN_END: begin
                n_state = S_CHK_L;
            end
            S_CHK_L: begin
                if (r_mid > r_left) begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = r_best_addr - ADDR_W'(1);
                    n_state   = S_WAIT_L;
                end else begin
                    n_state = S_CHK_R;
                end
            end
            S_WAIT_L: begin
                if (w_ge) begin
                    n_right = r_mid - COL_W'(1);
                    n_state = S_START;
                end else begin
                    n_state = S_CHK_R;
                end
            end
            S_CHK_R: begin
                if (r_mid < r_right) begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = r_best_addr + ADDR_W'(1);
                    n_state   = S_WAIT_R;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_WAIT_R: begin
                if (w_ge) begin
                    n_left  = r_mid + COL_W'(1);
                    n_state = S_START;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dv    <= w_scan_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_rows <= i_rows;
            r_cols <= i_cols;
        end
        r_left    <= n_left;
        r_right   <= n_right;
        r_mid     <= n_mid;
        r_row     <= n_row;
        r_addr    <= n_addr;
        r_dv_row  <= r_row;
        r_dv_addr <= r_addr;
        // first row loads unconditionally, later rows only when strictly greater
        if (r_dv && (r_dv_row == '0 || w_gt)) begin
            r_best      <= r_rdata;
            r_best_row  <= r_dv_row;
            r_best_addr <= r_dv_addr;
        end
    end

    assign o_stat.idle  = (r_state == S_IDLE);
    assign o_stat.done  = (r_state == S_DONE);
    assign o_peak.row   = PEAK_ROW_W'(r_best_row);
    assign o_peak.col   = PEAK_COL_W'(r_mid);
    assign o_peak.value = PEAK_VAL_W'(r_best);

endmodule

FILE: src/matrix_peak_finder_2d.sv
// Channel   Dir  Modport  Payload                          Beat when
// i_elem    in   sink     element_value[31:0]              valid && ready
// o_peak    out  source   peak_row[4:0] peak_col[4:0]      valid && ready
//                         peak_value[31:0]
// apb       in   slave    num_rows @0x0, num_cols @0x4     psel && penable && pwrite
//
// Loading takes one element per cycle while ready is high. The beat that completes
// the frame starts the search through one memory read port and one comparator, with
// ready low until the search hands its peak to the output register.
// The peak sits in an output register; loading the next frame goes on while
// it waits. Synchronous active-low reset clears control; the store is not cleared.
module matrix_peak_finder_2d #(
    parameter int MAX_ROWS   = 32,
    parameter int MAX_COLS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    mpf_in_if.sink                            i_elem,
    mpf_out_if.source                         o_peak,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mpf_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [mpf_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [mpf_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import mpf_pkg::*;

    localparam int DEPTH   = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ROWS_CW = $clog2(MAX_ROWS + 1);
    localparam int COLS_CW = $clog2(MAX_COLS + 1);
    localparam int TOT_W   = ROWS_CW + COLS_CW;

    logic [CFG_DIM_W-1:0] r_num_rows;
    logic [CFG_DIM_W-1:0] r_num_cols;
    logic [ADDR_W-1:0]    r_count;
    logic                 r_out_valid;
    t_peak                r_out;

    logic [ROWS_CW-1:0]   w_rows;
    logic [COLS_CW-1:0]   w_cols;
    logic [TOT_W-1:0]     w_total;
    logic                 w_in_acc;
    logic                 w_more;
    logic                 w_start;
    logic                 w_take;
    logic                 w_cfg_wr;
    t_srch_stat           w_stat;
    t_peak                w_peak;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows <= NUM_ROWS_RST;
            r_num_cols <= NUM_COLS_RST;
        end else if (w_cfg_wr) begin
            unique case (paddr[2])
                REG_NUM_ROWS: r_num_rows <= pwdata[CFG_DIM_W-1:0];
                REG_NUM_COLS: r_num_cols <= pwdata[CFG_DIM_W-1:0];
                default:      r_num_rows <= r_num_rows;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_NUM_ROWS: prdata = APB_DATA_W'(r_num_rows);
            REG_NUM_COLS: prdata = APB_DATA_W'(r_num_cols);
            default:      prdata = '0;
        endcase
    end

    // clamp dimensions to 1..MAX
    always_comb begin
        if (r_num_rows == '0) begin
            w_rows = ROWS_CW'(1);
        end else if (32'(r_num_rows) > 32'(MAX_ROWS)) begin
            w_rows = ROWS_CW'(MAX_ROWS);
        end else begin
            w_rows = ROWS_CW'(r_num_rows);
        end
        if (r_num_cols == '0) begin
            w_cols = COLS_CW'(1);
        end else if (32'(r_num_cols) > 32'(MAX_COLS)) begin
            w_cols = COLS_CW'(MAX_COLS);
        end else begin
            w_cols = COLS_CW'(r_num_cols);
        end
    end

    assign w_total  = TOT_W'(w_rows) * TOT_W'(w_cols);
    assign i_elem.ready = w_stat.idle;
    assign w_in_acc = i_elem.valid & w_stat.idle;
    assign w_more   = (TOT_W'(r_count) + TOT_W'(1)) < w_total;
    assign w_start  = w_in_acc & ~w_more;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_in_acc) begin
            r_count <= w_more ? r_count + ADDR_W'(1) : '0;
        end
    end

    mpf_search #(
        .MAX_ROWS   (MAX_ROWS),
        .MAX_COLS   (MAX_COLS),
        .VALUE_BITS (VALUE_BITS),
        .ROWS_CW    (ROWS_CW),
        .COLS_CW    (COLS_CW),
        .ADDR_W     (ADDR_W)
    ) u_search (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_in_acc),
        .i_wr_addr (r_count),
        .i_wr_data (VALUE_BITS'(i_elem.element_value)),
        .i_start   (w_start),
        .i_rows    (w_rows),
        .i_cols    (w_cols),
        .i_take    (w_take),
        .o_stat    (w_stat),
        .o_peak    (w_peak)
    );

    assign w_take = w_stat.done & (~r_out_valid | o_peak.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (o_peak.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out <= w_peak;
        end
    end

    assign o_peak.valid      = r_out_valid;
    assign o_peak.peak_row   = r_out.row;
    assign o_peak.peak_col   = r_out.col;
    assign o_peak.peak_value = r_out.value;

endmodule

FILE: verif/matrix_peak_finder_2d_tb.sv
module matrix_peak_finder_2d_tb;
    import mpf_pkg::*;

    localparam int DIM_MAX     = 32;
    localparam int SETTLE_CYC  = 300;
    localparam int HOLD_CYC    = 400;
    localparam int QUIET_LIMIT = 4000;

    localparam logic [APB_ADDR_W-1:0] ADDR_NUM_ROWS = {REG_NUM_ROWS, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_NUM_COLS = {REG_NUM_COLS, 2'b00};

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    mpf_in_if  elem_ch ();
    mpf_out_if peak_ch ();

    matrix_peak_finder_2d dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_elem  (elem_ch),
        .o_peak  (peak_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // mirror of the block state
    logic [ELEM_W-1:0]    elem_mirror [DIM_MAX*DIM_MAX];
    int unsigned          load_cnt = 0;
    logic [CFG_DIM_W-1:0] rows_reg = NUM_ROWS_RST;
    logic [CFG_DIM_W-1:0] cols_reg = NUM_COLS_RST;
    t_peak                expected_peaks [$];

    int err_cnt     = 0;
    int items_sent  = 0;
    int quiet_cyc   = 0;
    int rx_hold_cyc = 0;
    bit tx_gaps_on  = 1'b0;
    bit rx_gaps_on  = 1'b0;

    task automatic report_mismatch(input string what, input longint unsigned want,
                                   input longint unsigned got);
        $display("MISMATCH %s: expected 0x%0h, got 0x%0h", what, want, got);
        err_cnt++;
    endtask

    function automatic int unsigned eff_dim(input logic [CFG_DIM_W-1:0] raw);
        if (raw == 0) return 1;
        if (raw > DIM_MAX) return DIM_MAX;
        return raw;
    endfunction

    function automatic void predict_element(input logic [ELEM_W-1:0] v);
        int unsigned nr, nc, lo, hi, mid, best_row, r;
        logic [ELEM_W-1:0] best;
        bit found;
        t_peak pk;
        nr = eff_dim(rows_reg);
        nc = eff_dim(cols_reg);
        if (load_cnt < DIM_MAX * DIM_MAX) elem_mirror[load_cnt] = v;
        if (load_cnt + 1 < nr * nc) begin
            load_cnt++;
            return;
        end
        load_cnt = 0;
        lo = 0;
        hi = nc - 1;
        found = 1'b0;
        mid = 0;
        best_row = 0;
        best = '0;
        while (!found) begin
            mid = (lo + hi) / 2;
            best_row = 0;
            best = elem_mirror[mid];
            for (r = 1; r < nr; r++) begin
                if (elem_mirror[r * nc + mid] > best) begin
                    best = elem_mirror[r * nc + mid];
                    best_row = r;
                end
            end
            if (mid > lo && elem_mirror[best_row * nc + mid - 1] >= best) begin
                hi = mid - 1;
            end else if (mid < hi && elem_mirror[best_row * nc + mid + 1] >= best) begin
                lo = mid + 1;
            end else begin
                found = 1'b1;
            end
        end
        pk.row   = best_row[PEAK_ROW_W-1:0];
        pk.col   = mid[PEAK_COL_W-1:0];
        pk.value = best;
        expected_peaks.push_back(pk);
    endfunction

    // peak checker
    always @(posedge i_clk) begin
        t_peak want;
        if (i_rst_n && peak_ch.valid && peak_ch.ready) begin
            if (expected_peaks.size() == 0) begin
                report_mismatch("unexpected peak beat", 0,
                                {peak_ch.peak_row, peak_ch.peak_col, peak_ch.peak_value});
            end else begin
                want = expected_peaks.pop_front();
                if (peak_ch.peak_row !== want.row)
                    report_mismatch("peak_row", want.row, peak_ch.peak_row);
                if (peak_ch.peak_col !== want.col)
                    report_mismatch("peak_col", want.col, peak_ch.peak_col);
                if (peak_ch.peak_value !== want.value)
                    report_mismatch("peak_value", want.value, peak_ch.peak_value);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || psel || (elem_ch.valid && elem_ch.ready)
                || (peak_ch.valid && peak_ch.ready)) begin
            quiet_cyc = 0;
        end else begin
            quiet_cyc++;
        end
        if (quiet_cyc >= QUIET_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", quiet_cyc);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver: random stall bursts, plus a long hold-off on request
    initial begin
        int n;
        peak_ch.ready = 1'b0;
        @(posedge i_clk);
        forever begin
            if (rx_hold_cyc > 0) begin
                n = rx_hold_cyc;
                rx_hold_cyc = 0;
                peak_ch.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end else if (rx_gaps_on && $urandom_range(0, 11) == 0) begin
                peak_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end else begin
                peak_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    task automatic send_element(input logic [ELEM_W-1:0] v);
        if (tx_gaps_on && $urandom_range(0, 7) == 0) begin
            elem_ch.valid <= 1'b0;
            elem_ch.element_value <= $urandom();
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        elem_ch.valid <= 1'b1;
        elem_ch.element_value <= v;
        do @(posedge i_clk); while (!elem_ch.ready);
        predict_element(v);
        items_sent++;
    endtask

    task automatic wait_drained();
        elem_ch.valid <= 1'b0;
        while (expected_peaks.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic apb_xfer(input logic wr, input logic [APB_ADDR_W-1:0] addr,
                            input logic [APB_DATA_W-1:0] wdata,
                            output logic [APB_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_dims();
        logic [APB_DATA_W-1:0] rd;
        apb_xfer(1'b0, ADDR_NUM_ROWS, '0, rd);
        if (rd !== APB_DATA_W'(rows_reg)) report_mismatch("num_rows readback", rows_reg, rd);
        apb_xfer(1'b0, ADDR_NUM_COLS, '0, rd);
        if (rd !== APB_DATA_W'(cols_reg)) report_mismatch("num_cols readback", cols_reg, rd);
    endtask

    task automatic set_dims(input logic [CFG_DIM_W-1:0] r, input logic [CFG_DIM_W-1:0] c);
        logic [APB_DATA_W-1:0] rd;
        apb_xfer(1'b1, ADDR_NUM_ROWS, APB_DATA_W'(r), rd);
        rows_reg = r;
        apb_xfer(1'b1, ADDR_NUM_COLS, APB_DATA_W'(c), rd);
        cols_reg = c;
        check_dims();
    endtask

    function automatic logic [CFG_DIM_W-1:0] pick_dim();
        case ($urandom_range(0, 19))
            0:       return 0;
            1:       return $urandom_range(33, 63);
            2:       return 32;
            3:       return $urandom_range(7, 31);
            default: return $urandom_range(1, 6);
        endcase
    endfunction

    function automatic logic [ELEM_W-1:0] pick_value(input int mode);
        case (mode)
            0:       return $urandom_range(0, 3);
            1:       return 32'hFFFF_FFFF - $urandom_range(0, 2);
            default: return $urandom();
        endcase
    endfunction

    task automatic test_full_frame();
        check_dims();
        set_dims(DIM_MAX, DIM_MAX / 2);
        repeat (DIM_MAX * DIM_MAX / 2) send_element($urandom());
        wait_drained();
    endtask

    task automatic test_single_cell();
        set_dims(1, 1);
        send_element(32'h0000_0000);
        send_element(32'hFFFF_FFFF);
        wait_drained();
        // zero dims behave as one
        set_dims(0, 0);
        send_element($urandom());
        wait_drained();
    endtask

    task automatic test_plateau();
        set_dims(3, 3);
        repeat (9) send_element(32'h5A5A_5A5A);
        wait_drained();
    endtask

    task automatic test_climb_right();
        set_dims(1, 3);
        send_element(0);
        send_element(1);
        send_element(2);
        wait_drained();
    endtask

    task automatic test_resize_midload();
        set_dims(2, 3);
        repeat (4) send_element($urandom());
        wait_drained();
        set_dims(2, 2);
        send_element($urandom());
        wait_drained();
        set_dims(1, 2);
        send_element($urandom());
        wait_drained();
        set_dims(2, 2);
        repeat (3) send_element($urandom());
        wait_drained();
    endtask

    task automatic test_backpressure();
        set_dims(1, 1);
        rx_hold_cyc = HOLD_CYC;
        repeat (40) send_element($urandom());
        wait_drained();
    endtask

    task automatic test_random_frames(input int n_items, input bit gaps);
        int start, reps, total, len, mode;
        logic [CFG_DIM_W-1:0] r, c;
        tx_gaps_on = gaps;
        rx_gaps_on = gaps;
        start = items_sent;
        while (items_sent - start < n_items) begin
            r = pick_dim();
            c = pick_dim();
            if (eff_dim(r) > 6 && eff_dim(c) > 6) c = $urandom_range(0, 2);
            set_dims(r, c);
            reps = $urandom_range(1, 3);
            repeat (reps) begin
                total = eff_dim(r) * eff_dim(c);
                len = (total > load_cnt) ? total - load_cnt : 1;
                // a cut-short frame leaves a partial load for the next repetition or setting
                if (len > 1 && $urandom_range(0, 9) == 0) len = $urandom_range(1, len - 1);
                mode = $urandom_range(0, 3);
                repeat (len) send_element(pick_value(mode));
            end
            wait_drained();
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        elem_ch.valid = 1'b0;
        elem_ch.element_value = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_full_frame();
        test_single_cell();
        test_plateau();
        test_climb_right();
        test_resize_midload();
        test_backpressure();
        test_random_frames(280, 1'b1);
        test_random_frames(100, 1'b0);

        if (err_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: files.f
src/mpf_pkg.sv
src/mpf_in_if.sv
src/mpf_out_if.sv
src/mpf_search.sv
src/matrix_peak_finder_2d.sv
verif/matrix_peak_finder_2d_tb.sv
